/* rtl/core/pdcc_pkg.sv */
// ----------------------------------------------------------------------------
// pdcc_pkg: shared types and constants
// Event and action codes, gesture flag bundle and result field layout for the
// pointer drag/click classifier.
// ----------------------------------------------------------------------------
package pdcc_pkg;

  typedef enum logic [1:0] {
    MODE_PRESS   = 2'd0,
    MODE_MOVE    = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_PAN    = 3'd1,
    ACT_ORBIT  = 3'd2,
    ACT_SELECT = 3'd3,
    ACT_CANCEL = 3'd4
  } action_t;

  localparam logic [2:0] BTN_PRIMARY   = 3'd1;
  localparam logic [2:0] BTN_MIDDLE    = 3'd2;
  localparam logic [2:0] BTN_SECONDARY = 3'd3;

  localparam int BUTTON_WIDTH = 3;
  localparam int MODE_WIDTH   = 2;
  localparam int ACTION_WIDTH = 3;
  localparam int THRESH_WIDTH = 32;
  localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 32'd9216;

  // Deltas are 21-bit signed and saturate symmetrically.
  localparam int DELTA_WIDTH = 21;
  localparam int DELTA_LIM   = 1048575;

  // Result tdata layout, lowest bit first: delta_x, delta_y, gesture_active.
  localparam int OUT_ACTIVE_BIT = 2 * DELTA_WIDTH;
  localparam int OUT_DATA_WIDTH = ((2 * DELTA_WIDTH + 1 + 7) / 8) * 8;

  typedef struct packed {
    logic       armed;
    logic [1:0] held_button;
    logic       menu;
    logic       no_click;
    logic       drag;
  } gesture_flags_t;

endpackage

/* rtl/core/pointer_drag_click_classifier_core.sv */
// Path: an event is held in the input register, then passes the update logic
// into the output register.
// Throughput: one event per cycle while the output is not stalled; the
// gesture state updates in the same cycle that an event leaves the input
// register, so events may follow back to back. Reset: synchronous, clears
// both stages, the gesture state and sets the drag threshold to 9216.
// ----------------------------------------------------------------------------
// pointer_drag_click_classifier_core: tap versus drag gesture detector
// Classifies press, move, release and clear events into pan, orbit, select
// and cancel actions with position deltas.
// ----------------------------------------------------------------------------
module pointer_drag_click_classifier_core #(
  parameter int COORD_WIDTH = 20
) (
  input  logic clk,
  input  logic rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // tdata, lowest bit up: button, x_pos, y_pos, coords_valid, over_menu,
  // suppress_click_in, zero padding
  input  logic [((2*COORD_WIDTH+6+7)/8)*8-1:0] s_tdata,
  // tuser: mode
  input  logic [pdcc_pkg::MODE_WIDTH-1:0]     s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // tdata, lowest bit up: delta_x, delta_y, gesture_active, zero padding
  output logic [pdcc_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
  // tuser: action
  output logic [pdcc_pkg::ACTION_WIDTH-1:0]   m_tuser,
  input  logic                                cfg_wr_en,
  input  logic [pdcc_pkg::THRESH_WIDTH-1:0]   cfg_wr_data
);
  import pdcc_pkg::*;

  localparam int CW       = COORD_WIDTH;
  localparam int X_LO     = BUTTON_WIDTH;
  localparam int Y_LO     = BUTTON_WIDTH + CW;
  localparam int VALID_B  = BUTTON_WIDTH + 2 * CW;
  localparam int OUT_PAD  = OUT_DATA_WIDTH - 2 * DELTA_WIDTH - 1;

  // Input register
  logic                    in_valid;
  mode_t                   in_mode;
  logic [BUTTON_WIDTH-1:0] in_button;
  logic signed [CW-1:0]    in_x, in_y;
  logic                    in_cv, in_menu, in_supp;

  // Gesture state
  gesture_flags_t          flags, flags_next;
  logic signed [CW-1:0]    start_x, start_y, prev_x, prev_y;
  logic signed [CW-1:0]    start_x_next, start_y_next, prev_x_next, prev_y_next;
  logic [THRESH_WIDTH-1:0] drag_threshold_sq;

  // Result register
  logic                          out_valid;
  action_t                       res_action, out_action;
  logic signed [DELTA_WIDTH-1:0] res_dx, res_dy, out_dx, out_dy;
  logic                          out_active;

  logic advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  pdcc_step #(.COORD_WIDTH(CW)) u_step (
    .mode              (in_mode),
    .button            (in_button),
    .x_pos             (in_x),
    .y_pos             (in_y),
    .coords_valid      (in_cv),
    .over_menu         (in_menu),
    .suppress_click_in (in_supp),
    .drag_threshold_sq (drag_threshold_sq),
    .flags             (flags),
    .start_x           (start_x),
    .start_y           (start_y),
    .prev_x            (prev_x),
    .prev_y            (prev_y),
    .flags_next        (flags_next),
    .start_x_next      (start_x_next),
    .start_y_next      (start_y_next),
    .prev_x_next       (prev_x_next),
    .prev_y_next       (prev_y_next),
    .action            (res_action),
    .delta_x           (res_dx),
    .delta_y           (res_dy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode   <= mode_t'(s_tuser);
      in_button <= s_tdata[BUTTON_WIDTH-1:0];
      in_x      <= s_tdata[X_LO +: CW];
      in_y      <= s_tdata[Y_LO +: CW];
      in_cv     <= s_tdata[VALID_B];
      in_menu   <= s_tdata[VALID_B+1];
      in_supp   <= s_tdata[VALID_B+2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drag_threshold_sq <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      drag_threshold_sq <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags   <= '0;
      start_x <= '0;
      start_y <= '0;
      prev_x  <= '0;
      prev_y  <= '0;
    end else if (advance) begin
      flags   <= flags_next;
      start_x <= start_x_next;
      start_y <= start_y_next;
      prev_x  <= prev_x_next;
      prev_y  <= prev_y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_action <= res_action;
      out_dx     <= res_dx;
      out_dy     <= res_dy;
      out_active <= flags_next.armed;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_action;
  assign m_tdata  = {{OUT_PAD{1'b0}}, out_active, out_dy, out_dx};

endmodule

/* rtl/core/pdcc_step.sv */
// ----------------------------------------------------------------------------
// pdcc_step: single-event gesture update
// Combinational next-state and result logic for one pointer event, given the
// current gesture state and the drag threshold.
// ----------------------------------------------------------------------------
module pdcc_step #(
  parameter int COORD_WIDTH = 20
) (
  input  pdcc_pkg::mode_t                    mode,
  input  logic [pdcc_pkg::BUTTON_WIDTH-1:0]  button,
  input  logic signed [COORD_WIDTH-1:0]      x_pos,
  input  logic signed [COORD_WIDTH-1:0]      y_pos,
  input  logic                               coords_valid,
  input  logic                               over_menu,
  input  logic                               suppress_click_in,
  input  logic [pdcc_pkg::THRESH_WIDTH-1:0]  drag_threshold_sq,
  input  pdcc_pkg::gesture_flags_t           flags,
  input  logic signed [COORD_WIDTH-1:0]      start_x,
  input  logic signed [COORD_WIDTH-1:0]      start_y,
  input  logic signed [COORD_WIDTH-1:0]      prev_x,
  input  logic signed [COORD_WIDTH-1:0]      prev_y,
  output pdcc_pkg::gesture_flags_t           flags_next,
  output logic signed [COORD_WIDTH-1:0]      start_x_next,
  output logic signed [COORD_WIDTH-1:0]      start_y_next,
  output logic signed [COORD_WIDTH-1:0]      prev_x_next,
  output logic signed [COORD_WIDTH-1:0]      prev_y_next,
  output pdcc_pkg::action_t                  action,
  output logic signed [pdcc_pkg::DELTA_WIDTH-1:0] delta_x,
  output logic signed [pdcc_pkg::DELTA_WIDTH-1:0] delta_y
);
  import pdcc_pkg::*;

  localparam int AW = (COORD_WIDTH + 1 > 17) ? COORD_WIDTH + 1 : 17;
  localparam int DW = (COORD_WIDTH + 2 > DELTA_WIDTH + 1) ? COORD_WIDTH + 2 : DELTA_WIDTH + 1;
  localparam logic signed [DW-1:0] LIM_P = DW'(DELTA_LIM);
  localparam logic signed [DW-1:0] LIM_N = -LIM_P;

  logic signed [COORD_WIDTH:0] sdx, sdy, pdx, pdy;
  logic [COORD_WIDTH:0]        adx, ady;
  logic [AW-1:0]               adx_e, ady_e;
  logic [31:0]                 sq_x, sq_y;
  logic [32:0]                 sq_sum;
  logic                        far;
  logic                        move_drag;
  logic                        click;
  logic signed [DW-1:0]        pdx_e, pdy_e;
  logic signed [DELTA_WIDTH-1:0] sat_dx, sat_dy;
  logic                        held_match;

  function automatic logic signed [DELTA_WIDTH-1:0] sat_delta(input logic signed [DW-1:0] d);
    logic signed [DW-1:0] r;
    begin
      r = d;
      if (d > LIM_P) begin
        r = LIM_P;
      end else if (d < LIM_N) begin
        r = LIM_N;
      end
      return r[DELTA_WIDTH-1:0];
    end
  endfunction

  assign sdx = {x_pos[COORD_WIDTH-1], x_pos} - {start_x[COORD_WIDTH-1], start_x};
  assign sdy = {y_pos[COORD_WIDTH-1], y_pos} - {start_y[COORD_WIDTH-1], start_y};
  assign pdx = {x_pos[COORD_WIDTH-1], x_pos} - {prev_x[COORD_WIDTH-1], prev_x};
  assign pdy = {y_pos[COORD_WIDTH-1], y_pos} - {prev_y[COORD_WIDTH-1], prev_y};

  // The magnitude of the most negative difference reads correctly as unsigned.
  assign adx   = sdx[COORD_WIDTH] ? (~sdx + 1'b1) : sdx;
  assign ady   = sdy[COORD_WIDTH] ? (~sdy + 1'b1) : sdy;
  assign adx_e = AW'(adx);
  assign ady_e = AW'(ady);

  // A component of 2^16 or more squares past any 32-bit threshold, so only the
  // low sixteen bits need a squarer.
  assign sq_x   = adx_e[15:0] * adx_e[15:0];
  assign sq_y   = ady_e[15:0] * ady_e[15:0];
  assign sq_sum = {1'b0, sq_x} + {1'b0, sq_y};
  assign far    = (|adx_e[AW-1:16]) || (|ady_e[AW-1:16]) ||
                  (sq_sum >= {1'b0, drag_threshold_sq});
  assign move_drag = flags.drag || far;

  assign pdx_e  = {{(DW-COORD_WIDTH-1){pdx[COORD_WIDTH]}}, pdx};
  assign pdy_e  = {{(DW-COORD_WIDTH-1){pdy[COORD_WIDTH]}}, pdy};
  assign sat_dx = sat_delta(pdx_e);
  assign sat_dy = sat_delta(pdy_e);

  assign held_match = ({1'b0, flags.held_button} == button);
  assign click      = coords_valid && !move_drag && !flags.no_click;

  always_comb begin
    flags_next   = flags;
    start_x_next = start_x;
    start_y_next = start_y;
    prev_x_next  = prev_x;
    prev_y_next  = prev_y;
    action       = ACT_NONE;
    delta_x      = '0;
    delta_y      = '0;

    unique case (mode)
      MODE_PRESS: begin
        if (!flags.armed && button >= BTN_PRIMARY && button <= BTN_SECONDARY &&
            coords_valid) begin
          flags_next.armed       = 1'b1;
          flags_next.held_button = button[1:0];
          flags_next.menu        = over_menu;
          flags_next.no_click    = suppress_click_in;
          flags_next.drag        = 1'b0;
          start_x_next           = x_pos;
          start_y_next           = y_pos;
          prev_x_next            = x_pos;
          prev_y_next            = y_pos;
        end
      end
      MODE_MOVE: begin
        if (flags.armed && coords_valid) begin
          flags_next.drag = move_drag;
          if (move_drag) begin
            delta_x     = sat_dx;
            delta_y     = sat_dy;
            prev_x_next = x_pos;
            prev_y_next = y_pos;
            if (!flags.menu) begin
              action = ({1'b0, flags.held_button} == BTN_SECONDARY) ? ACT_ORBIT : ACT_PAN;
            end
          end
        end
      end
      MODE_RELEASE: begin
        if (flags.armed && held_match) begin
          flags_next   = '0;
          start_x_next = '0;
          start_y_next = '0;
          prev_x_next  = '0;
          prev_y_next  = '0;
          if (click) begin
            if (button == BTN_PRIMARY) begin
              action = ACT_SELECT;
            end else if (button == BTN_SECONDARY) begin
              action = ACT_CANCEL;
            end
          end
        end
      end
      MODE_CLEAR: begin
        flags_next   = '0;
        start_x_next = '0;
        start_y_next = '0;
        prev_x_next  = '0;
        prev_y_next  = '0;
      end
      default: begin
        flags_next = flags;
      end
    endcase
  end

endmodule

/* rtl/core/pdcc_checker.sv */
// ----------------------------------------------------------------------------
// pdcc_checker: port-level checks for the classifier
// Watches the result stream for handshake stability and for combinations of
// action, deltas and gesture state that the classifier can never produce.
// ----------------------------------------------------------------------------
module pdcc_checker (
  input logic clk,
  input logic rst,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [pdcc_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
  input logic [pdcc_pkg::ACTION_WIDTH-1:0]   m_tuser
);
  import pdcc_pkg::*;

  logic dragging_act, click_act, deltas_zero;

  assign dragging_act = (m_tuser == ACT_PAN) || (m_tuser == ACT_ORBIT);
  assign click_act    = (m_tuser == ACT_SELECT) || (m_tuser == ACT_CANCEL);
  assign deltas_zero  = (m_tdata[2*DELTA_WIDTH-1:0] == '0);

  // A stalled result holds still until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Pan and orbit only come from a gesture that stays armed.
  a_drag_armed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && dragging_act |-> m_tdata[OUT_ACTIVE_BIT])
    else $error("drag action without an armed gesture");

  // A click ends the gesture and carries no movement.
  a_click_ends: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && click_act |-> !m_tdata[OUT_ACTIVE_BIT] && deltas_zero)
    else $error("click result with armed gesture or nonzero deltas");

  // Movement is reported only while a gesture is armed.
  a_delta_armed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !deltas_zero |-> m_tdata[OUT_ACTIVE_BIT] && !click_act)
    else $error("deltas reported outside a drag");

  // Nothing left in either stage after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("pipeline not empty after reset");

endmodule

bind pointer_drag_click_classifier_core pdcc_checker u_pdcc_checker (.*);
